[src/sswp_pkg.sv]
// ----------------------------------------------------------------------------
// sswp_pkg
// Shared types and constants for the screen write to pixel converter.
// ----------------------------------------------------------------------------
package sswp_pkg;

  localparam int BITMAP_BYTES    = 6144;
  localparam int ATTRIBUTE_BYTES = 768;
  localparam int BM_AW           = $clog2(BITMAP_BYTES);
  localparam int AT_AW           = $clog2(ATTRIBUTE_BYTES);

  localparam logic [15:0] SCREEN_BASE = 16'h4000;
  localparam logic [15:0] ATTR_BASE   = 16'h5800;
  localparam logic [15:0] SCREEN_END  = 16'h5B00;

  localparam int BRIGHT_BIT = 6;

  localparam logic [15:0] BLUE_RST  = 16'd15;
  localparam logic [15:0] RED_RST   = 16'd30720;
  localparam logic [15:0] GREEN_RST = 16'd992;
  localparam logic [5:0]  ORG_X_RST = 6'd32;
  localparam logic [5:0]  ORG_Y_RST = 6'd24;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  typedef enum logic [2:0] {
    REG_BLUE  = 3'd0,
    REG_RED   = 3'd1,
    REG_GREEN = 3'd2,
    REG_ORG_X = 3'd3,
    REG_ORG_Y = 3'd4,
    REG_MONO  = 3'd5
  } reg_idx_e;

endpackage

[src/sswp_if.sv]
// ----------------------------------------------------------------------------
// sswp_in_if / sswp_out_if
// Valid/ready channels for snooped writes and emitted pixels.
// ----------------------------------------------------------------------------
interface sswp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] address;
  logic [7:0]  write_data;

  modport source (output valid, output address, output write_data, input ready);
  modport sink   (input valid, input address, input write_data, output ready);
endinterface

interface sswp_out_if;
  logic        valid;
  logic        ready;
  logic [8:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] colour;
  logic        last;

  modport source (output valid, output pixel_x, output pixel_y, output colour,
                  output last, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input colour,
                  input last, output ready);
endinterface

[src/snooped_screen_write_to_pixels_core.sv]
// ----------------------------------------------------------------------------
// snooped_screen_write_to_pixels_core
// Converts snooped screen memory writes into RGB565 pixels on a panel.
// ----------------------------------------------------------------------------
// Bitmap write: one store/attribute lookup (ST_READ), then 8 pixels (ST_EMIT).
// Attribute write: 8 rows, each one bitmap read (ST_READ) then 8 pixels (ST_EMIT).
// One pixel per cycle unless out_o stalls; ready only when idle, set by the row sequencer.
// Writes outside the screen and mono-mode attribute writes are accepted with no output.
// Reset: async, active low; then a clearing pass zeroes both stores,
// during which no write is accepted (register writes are taken).
module snooped_screen_write_to_pixels_core
  import sswp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  sswp_in_if.sink            in_i,
  sswp_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_READ  = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_e;

  state_e           state_q, state_d;
  logic [BM_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic [12:0]      off_q, off_d;
  logic [7:0]       data_q, data_d;
  logic             attr_mode_q, attr_mode_d;
  logic [2:0]       pix_q, pix_d;

  logic [15:0] blue_q, red_q, green_q;
  logic [5:0]  org_x_q, org_y_q;
  logic        mono_q;

  // Configuration port
  reg_idx_e reg_idx;
  logic     cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blue_q  <= BLUE_RST;
      red_q   <= RED_RST;
      green_q <= GREEN_RST;
      org_x_q <= ORG_X_RST;
      org_y_q <= ORG_Y_RST;
      mono_q  <= 1'b0;
    end else if (cfg_we) begin
      case (reg_idx)
        REG_BLUE:  blue_q  <= pwdata[15:0];
        REG_RED:   red_q   <= pwdata[15:0];
        REG_GREEN: green_q <= pwdata[15:0];
        REG_ORG_X: org_x_q <= pwdata[5:0];
        REG_ORG_Y: org_y_q <= pwdata[5:0];
        REG_MONO:  mono_q  <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BLUE:  prdata = {16'd0, blue_q};
      REG_RED:   prdata = {16'd0, red_q};
      REG_GREEN: prdata = {16'd0, green_q};
      REG_ORG_X: prdata = {26'd0, org_x_q};
      REG_ORG_Y: prdata = {26'd0, org_y_q};
      REG_MONO:  prdata = {31'd0, mono_q};
      default:   prdata = '0;
    endcase
  end

  // Stores
  logic             bm_we, bm_re, at_we, at_re;
  logic [BM_AW-1:0] bm_waddr;
  logic [AT_AW-1:0] at_addr, at_waddr;
  logic [7:0]       bm_wdata, at_wdata, bm_rdata, at_rdata;
  logic             clearing;

  assign clearing = (state_q == ST_CLEAR);
  assign at_addr  = {off_q[12:11], off_q[7:0]};

  assign bm_we    = clearing || (state_q == ST_READ && !attr_mode_q);
  assign bm_waddr = clearing ? clr_cnt_q : off_q;
  assign bm_wdata = clearing ? 8'd0 : data_q;
  assign bm_re    = (state_q == ST_READ) && attr_mode_q;

  assign at_we    = (clearing && clr_cnt_q < BM_AW'(ATTRIBUTE_BYTES))
                    || (state_q == ST_READ && attr_mode_q);
  assign at_waddr = clearing ? clr_cnt_q[AT_AW-1:0] : at_addr;
  assign at_wdata = clearing ? 8'd0 : data_q;
  assign at_re    = (state_q == ST_READ) && !attr_mode_q;

  sswp_ram #(.WIDTH(8), .DEPTH(BITMAP_BYTES)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (bm_we),
    .waddr_i(bm_waddr),
    .wdata_i(bm_wdata),
    .re_i   (bm_re),
    .raddr_i(off_q),
    .rdata_o(bm_rdata)
  );

  sswp_ram #(.WIDTH(8), .DEPTH(ATTRIBUTE_BYTES)) u_attr (
    .clk_i  (clk_i),
    .we_i   (at_we),
    .waddr_i(at_waddr),
    .wdata_i(at_wdata),
    .re_i   (at_re),
    .raddr_i(at_addr),
    .rdata_o(at_rdata)
  );

  // Pixel datapath
  logic [7:0]  attr, bits;
  logic [15:0] lb, lr, lg, ink, paper;
  logic        bright, last_pix, row_last;

  assign attr   = attr_mode_q ? data_q : at_rdata;
  assign bits   = attr_mode_q ? bm_rdata : data_q;
  assign bright = attr[BRIGHT_BIT];
  assign lb     = bright ? {blue_q[14:0], 1'b0} : blue_q;
  assign lr     = bright ? {red_q[14:0], 1'b0} : red_q;
  assign lg     = bright ? {green_q[14:0], 1'b0} : green_q;

  always_comb begin
    if (mono_q) begin
      ink   = '0;
      paper = red_q | green_q | blue_q;
    end else begin
      ink   = ({16{attr[0]}} & lb) | ({16{attr[1]}} & lr) | ({16{attr[2]}} & lg);
      paper = ({16{attr[3]}} & lb) | ({16{attr[4]}} & lr) | ({16{attr[5]}} & lg);
    end
  end

  assign row_last = !attr_mode_q || (off_q[10:8] == 3'd7);
  assign last_pix = (pix_q == 3'd7) && row_last;

  assign out_o.valid   = (state_q == ST_EMIT);
  assign out_o.pixel_x = {1'b0, off_q[4:0], pix_q} + {3'd0, org_x_q};
  assign out_o.pixel_y = {off_q[12:11], off_q[7:5], off_q[10:8]} + {2'd0, org_y_q};
  assign out_o.colour  = bits[~pix_q] ? ink : paper;
  assign out_o.last    = last_pix;

  assign in_i.ready = (state_q == ST_IDLE);

  // Sequencer
  logic in_fire, out_fire, is_bm, is_at;

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = out_o.valid && out_o.ready;
  assign is_bm    = (in_i.address >= SCREEN_BASE) && (in_i.address < ATTR_BASE);
  assign is_at    = (in_i.address >= ATTR_BASE) && (in_i.address < SCREEN_END);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    off_d       = off_q;
    data_d      = data_q;
    attr_mode_d = attr_mode_q;
    pix_d       = pix_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == BM_AW'(BITMAP_BYTES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        pix_d = '0;
        if (in_fire) begin
          data_d = in_i.write_data;
          if (is_bm) begin
            off_d       = in_i.address[12:0];
            attr_mode_d = 1'b0;
            state_d     = ST_READ;
          end else if (is_at && !mono_q) begin
            off_d       = {in_i.address[9:8], 3'd0, in_i.address[7:0]};
            attr_mode_d = 1'b1;
            state_d     = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_fire) begin
          pix_d = pix_q + 1'b1;
          if (pix_q == 3'd7) begin
            if (row_last) begin
              state_d = ST_IDLE;
            end else begin
              off_d[10:8] = off_q[10:8] + 1'b1;
              state_d     = ST_READ;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pix_q       <= '0;
      attr_mode_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pix_q       <= pix_d;
      attr_mode_q <= attr_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q  <= off_d;
    data_q <= data_d;
  end

endmodule

[src/sswp_ram.sv]
// ----------------------------------------------------------------------------
// sswp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sswp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/sswp_checker.sv]
// ----------------------------------------------------------------------------
// sswp_checker
// Port-level checks for the screen write to pixel converter.
// ----------------------------------------------------------------------------
module sswp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [8:0]  pixel_x,
  input logic [7:0]  pixel_y,
  input logic [15:0] colour,
  input logic        last
);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
      && $stable(colour) && $stable(last))
    else $error("stalled pixel changed");

  // one write at a time: never ready while a pixel is valid
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && out_valid))
    else $error("input ready while emitting");

  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && last |=> !out_valid)
    else $error("pixel after last");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && !last |=> !in_ready)
    else $error("ready before last pixel");

endmodule

bind snooped_screen_write_to_pixels_core sswp_checker u_sswp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .in_valid (in_i.valid),
  .in_ready (in_i.ready),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .pixel_x  (out_o.pixel_x),
  .pixel_y  (out_o.pixel_y),
  .colour   (out_o.colour),
  .last     (out_o.last)
);
